// ===== rtl/mlp_pkg.sv =====
// Shared types, register codes, constants and fixed-point helpers of the network engine.
`timescale 1ns / 1ps

package mlp_pkg;

    localparam int MAX_INPUTS_DEF      = 64;
    localparam int MAX_LAYERS_DEF      = 4;
    localparam int MAX_LAYER_NODES_DEF = 64;
    localparam int MAX_OUTPUTS_DEF     = 16;
    localparam int MAX_WEIGHTS_DEF     = 4096;

    // Item kinds.
    localparam logic [1:0] KIND_WEIGHT  = 2'd0;
    localparam logic [1:0] KIND_NORM    = 2'd1;
    localparam logic [1:0] KIND_FEATURE = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_NUM_INPUTS    = 3'd0;
    localparam logic [2:0] CFG_NUM_LAYERS    = 3'd1;
    localparam logic [2:0] CFG_LAYER_SIZES   = 3'd2;
    localparam logic [2:0] CFG_NUM_OUTPUTS   = 3'd3;
    localparam logic [2:0] CFG_MODE          = 3'd4;
    localparam logic [2:0] CFG_OUTPUT_SCALE  = 3'd5;
    localparam logic [2:0] CFG_OUTPUT_OFFSET = 3'd6;

    // Register reset values.
    localparam logic [6:0]         RST_NUM_INPUTS    = 7'd1;
    localparam logic [2:0]         RST_NUM_LAYERS    = 3'd1;
    localparam logic [31:0]        RST_LAYER_SIZES   = 32'h0101_0101;
    localparam logic [4:0]         RST_NUM_OUTPUTS   = 5'd1;
    localparam logic [1:0]         RST_MODE          = 2'd0;
    localparam logic signed [31:0] RST_OUTPUT_SCALE  = 32'sd65536;
    localparam logic signed [31:0] RST_OUTPUT_OFFSET = 32'sd0;

    // Q16.16 constants of the sigmoid approximation.
    localparam logic signed [47:0] SIG_LIMIT = 48'sd2949120;   // 45.0
    localparam logic [31:0]        Q_ONE     = 32'd65536;      // 1.0

    typedef struct packed {
        logic [1:0]         kind;
        logic [11:0]        index;
        logic signed [31:0] value;
        logic signed [31:0] base;
        logic signed [31:0] span;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [3:0]         node_index;
        logic signed [31:0] result_value;
        logic               final_res;
    } res_t;

    // Saturates a 50-bit sum to the 48-bit accumulator range.
    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [47:0] r;
        if ((&v[49:47]) || !(|v[49:47])) begin
            r = v[47:0];
        end else if (v[49]) begin
            r = {1'b1, 47'd0};
        end else begin
            r = {1'b0, {47{1'b1}}};
        end
        return r;
    endfunction

    // Saturates a 66-bit value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if ((&v[65:31]) || !(|v[65:31])) begin
            r = v[31:0];
        end else if (v[65]) begin
            r = {1'b1, 31'd0};
        end else begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

    // Piecewise sigmoid of a Q16.16 accumulator value, clamped beyond +/-45.
    function automatic logic signed [31:0] sigmoid_q(input logic signed [47:0] x);
        logic [47:0] a;
        logic [31:0] y;
        logic [31:0] r;
        a = x[47] ? 48'(-x) : 48'(x);
        if (a >= 48'd327680) begin
            y = Q_ONE;
        end else if (a >= 48'd155648) begin
            y = 32'(a >> 5) + 32'd55296;
        end else if (a >= 48'd65536) begin
            y = 32'(a >> 3) + 32'd40960;
        end else begin
            y = 32'(a >> 2) + 32'd32768;
        end
        if (x < -SIG_LIMIT) begin
            r = 32'd0;
        end else if (x > SIG_LIMIT) begin
            r = Q_ONE;
        end else if (x[47]) begin
            r = Q_ONE - y;
        end else begin
            r = y;
        end
        return $signed(r);
    endfunction

endpackage

// ===== rtl/mlp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mlp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mlp_forward_inference.sv =====
// Top level of the sigmoid network engine: item decode, sequencer and shared MAC datapath.
// Load items (normalization pair, feature without last) are decoded and stored; weights add a write state.
// A pass prepares each input column (divided by its span where enabled), then runs
// each node as a MAC over its fan-in on the one shared multiplier and scales
// numeric outputs.
// Reset restores register defaults; the RAMs are not cleared and hold no valid bits.
`timescale 1ns / 1ps

module mlp_forward_inference #(
    parameter int MAX_INPUTS      = mlp_pkg::MAX_INPUTS_DEF,
    parameter int MAX_LAYERS      = mlp_pkg::MAX_LAYERS_DEF,
    parameter int MAX_LAYER_NODES = mlp_pkg::MAX_LAYER_NODES_DEF,
    parameter int MAX_OUTPUTS     = mlp_pkg::MAX_OUTPUTS_DEF,
    parameter int MAX_WEIGHTS     = mlp_pkg::MAX_WEIGHTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  mlp_pkg::item_t item,
    output logic           res_valid,
    input  logic           res_stall,
    output mlp_pkg::res_t  res,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data
);

    import mlp_pkg::*;

    // Address and counter widths, all derived from the size parameters.
    localparam int IN_AW     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int ACT_DEPTH = MAX_LAYERS * MAX_LAYER_NODES;
    localparam int ACT_AW    = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
    localparam int WT_AW     = $clog2(MAX_WEIGHTS);
    localparam int CNT_MAX_A = (MAX_INPUTS > MAX_LAYER_NODES) ? MAX_INPUTS : MAX_LAYER_NODES;
    localparam int CNT_MAX   = (CNT_MAX_A > MAX_OUTPUTS) ? CNT_MAX_A : MAX_OUTPUTS;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);
    localparam int LAY_W     = $clog2(MAX_LAYERS + 1);
    localparam int OUT_LIM   = (MAX_OUTPUTS < 16) ? MAX_OUTPUTS : 16;
    // Reciprocal for the weight address reduction; the estimate is low by at most one.
    localparam int WT_RECIP  = (1 << 24) / MAX_WEIGHTS;

    // Sequencer states.
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DEC   = 5'd1;
    localparam logic [4:0] S_WWR   = 5'd2;
    localparam logic [4:0] S_NRD   = 5'd3;
    localparam logic [4:0] S_NCALC = 5'd4;
    localparam logic [4:0] S_NDIV  = 5'd5;
    localparam logic [4:0] S_NDWR  = 5'd6;
    localparam logic [4:0] S_BRD   = 5'd7;
    localparam logic [4:0] S_BLD   = 5'd8;
    localparam logic [4:0] S_MRD   = 5'd9;
    localparam logic [4:0] S_MMUL  = 5'd10;
    localparam logic [4:0] S_MACC  = 5'd11;
    localparam logic [4:0] S_NFIN  = 5'd12;
    localparam logic [4:0] S_OM1   = 5'd13;
    localparam logic [4:0] S_OM2   = 5'd14;
    localparam logic [4:0] S_OSUM  = 5'd15;
    localparam logic [4:0] S_EMIT  = 5'd16;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    // Configuration registers.
    logic [6:0]         num_inputs_reg;
    logic [2:0]         num_layers_reg;
    logic [31:0]        layer_sizes_reg;
    logic [4:0]         num_outputs_reg;
    logic [1:0]         mode_reg;
    logic signed [31:0] output_scale_reg;
    logic signed [31:0] output_offset_reg;

    // Sequencer counters and pointers.
    logic [CNT_W-1:0]  k_reg;          // column during preparation, fan-in index in a node
    logic [CNT_W-1:0]  j_reg;          // node within the current layer
    logic [CNT_W-1:0]  prev_n_reg;     // fan-in of the current layer
    logic [LAY_W-1:0]  l_reg;          // layer; equal to the layer count on the output layer
    logic [WT_AW-1:0]  wptr_reg;       // rows are contiguous, so one running weight pointer
    logic [ACT_AW-1:0] rd_base_reg;
    logic [ACT_AW-1:0] wr_base_reg;
    logic [5:0]        div_cnt_reg;

    // Datapath registers.
    item_t              item_reg;
    logic [11:0]        wq_reg;
    logic signed [47:0] acc_reg;
    logic signed [64:0] prod_reg;
    logic signed [64:0] phi_reg;
    logic [31:0]        div_rem_reg;
    logic [47:0]        div_num_reg;
    logic [47:0]        div_q_reg;
    logic [31:0]        div_den_reg;
    logic               div_neg_reg;
    logic signed [31:0] res_val_reg;
    logic               res_valid_reg;
    res_t               res_reg;

    // RAM ports.
    logic [31:0]       w_rdata;
    logic [WT_AW-1:0]  w_waddr;
    logic              w_we;
    logic [63:0]       norm_rdata;
    logic              norm_we;
    logic [31:0]       feat_rdata;
    logic              feat_we;
    logic [31:0]       xin_rdata;
    logic [31:0]       xin_wdata;
    logic              xin_we;
    logic [31:0]       act_rdata;
    logic              act_we;
    logic [ACT_AW-1:0] act_raddr;
    logic [ACT_AW-1:0] act_waddr;
    logic [IN_AW-1:0]  col_addr;
    logic [IN_AW-1:0]  k_addr;

    // Derived control values.
    logic [CNT_W-1:0]   ni_eff;
    logic [LAY_W-1:0]   nl_eff;
    logic [CNT_W-1:0]   no_eff;
    logic [3:0]         l4;
    logic [7:0]         sz_byte;
    logic [7:0]         sz_cur;
    logic               is_out;
    logic [CNT_W-1:0]   node_cnt;
    logic [CNT_W-1:0]   k_inc;
    logic [CNT_W-1:0]   j_inc;
    logic               col_ok;
    logic               item_accept;
    logic               res_free;
    logic               node_last;

    // Arithmetic.
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_p;
    logic [32:0]        wq_prod;
    logic [31:0]        wq_mul;
    logic [31:0]        wr_diff;
    logic [31:0]        wmod;
    logic signed [31:0] feat_s;
    logic signed [31:0] nbase_s;
    logic signed [31:0] nspan_s;
    logic signed [31:0] norm_d;
    logic [31:0]        d_mag;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic signed [65:0] quot_s;
    logic signed [47:0] mac_sum;
    logic signed [31:0] numeric_res;
    logic signed [31:0] sig_acc;

    assign cfg_ready   = 1'b1;
    assign item_stall  = (state_reg != S_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign res_free    = !res_valid_reg || !res_stall;
    assign res_valid   = res_valid_reg;
    assign res         = res_reg;

    // Effective counts: zero reads as one, and each count saturates at its capacity.
    always_comb
    begin
        if (num_inputs_reg == 7'd0)
        begin
            ni_eff = CNT_W'(1);
        end
        else if ({25'd0, num_inputs_reg} > 32'(MAX_INPUTS))
        begin
            ni_eff = CNT_W'(MAX_INPUTS);
        end
        else
        begin
            ni_eff = CNT_W'(num_inputs_reg);
        end

        if (num_layers_reg == 3'd0)
        begin
            nl_eff = LAY_W'(1);
        end
        else if ({29'd0, num_layers_reg} > 32'(MAX_LAYERS))
        begin
            nl_eff = LAY_W'(MAX_LAYERS);
        end
        else
        begin
            nl_eff = LAY_W'(num_layers_reg);
        end

        if (num_outputs_reg == 5'd0)
        begin
            no_eff = CNT_W'(1);
        end
        else if ({27'd0, num_outputs_reg} > 32'(OUT_LIM))
        begin
            no_eff = CNT_W'(OUT_LIM);
        end
        else
        begin
            no_eff = CNT_W'(num_outputs_reg);
        end

        // Only four layer sizes are held; deeper layers have a single node.
        l4 = 4'(l_reg);
        if (l4 < 4'd4)
        begin
            sz_byte = layer_sizes_reg[{l4[1:0], 3'b000} +: 8];
        end
        else
        begin
            sz_byte = 8'd1;
        end
        if (sz_byte == 8'd0)
        begin
            sz_cur = 8'd1;
        end
        else if (sz_byte > 8'(MAX_LAYER_NODES))
        begin
            sz_cur = 8'(MAX_LAYER_NODES);
        end
        else
        begin
            sz_cur = sz_byte;
        end
    end

    assign is_out    = (l_reg == nl_eff);
    assign node_cnt  = is_out ? no_eff : CNT_W'(sz_cur);
    assign k_inc     = CNT_W'(k_reg + 1'b1);
    assign j_inc     = CNT_W'(j_reg + 1'b1);
    assign node_last = (j_inc == node_cnt);
    assign col_ok    = ({20'd0, item_reg.index} < 32'(MAX_INPUTS));
    assign col_addr  = item_reg.index[IN_AW-1:0];
    assign k_addr    = k_reg[IN_AW-1:0];

    // Weight address reduction modulo the store depth: a reciprocal estimate taken
    // in decode, then one multiply-back and a single corrective subtract.
    assign wq_prod = 33'(item_reg.index) * 33'(WT_RECIP);
    assign wq_mul  = 32'(wq_reg) * 32'(MAX_WEIGHTS);
    assign wr_diff = 32'(item_reg.index) - wq_mul;
    assign wmod    = (wr_diff >= 32'(MAX_WEIGHTS)) ? wr_diff - 32'(MAX_WEIGHTS) : wr_diff;
    assign w_waddr = WT_AW'(wmod);
    assign w_we    = (state_reg == S_WWR);

    assign norm_we = (state_reg == S_DEC) && (item_reg.kind == KIND_NORM) && col_ok;
    assign feat_we = (state_reg == S_DEC) && (item_reg.kind == KIND_FEATURE) && col_ok;

    // Normalization: saturated difference, then an optional divide by the span.
    assign feat_s  = $signed(feat_rdata);
    assign nbase_s = $signed(norm_rdata[31:0]);
    assign nspan_s = $signed(norm_rdata[63:32]);
    assign norm_d  = sat32(66'(feat_s) - 66'(nbase_s));
    assign d_mag   = norm_d[31] ? 32'(-norm_d) : 32'(norm_d);

    // One restoring divide step per cycle on magnitudes.
    assign rem_sh  = {div_rem_reg, div_num_reg[47]};
    assign rem_ge  = (rem_sh >= {1'b0, div_den_reg});
    assign quot_s  = div_neg_reg ? -$signed({18'd0, div_q_reg}) : $signed({18'd0, div_q_reg});

    always_comb
    begin
        xin_we    = 1'b0;
        xin_wdata = feat_rdata;
        if (state_reg == S_NCALC)
        begin
            if (!mode_reg[0])
            begin
                xin_we = 1'b1;
            end
            else if (nspan_s == 32'sd0)
            begin
                xin_we    = 1'b1;
                xin_wdata = norm_d;
            end
        end
        else if (state_reg == S_NDWR)
        begin
            xin_we    = 1'b1;
            xin_wdata = sat32(quot_s);
        end
    end

    // Activations of layer l sit in row l; the node reads row l-1 (layer 0 reads inputs).
    assign act_raddr = ACT_AW'(rd_base_reg + ACT_AW'(k_reg));
    assign act_waddr = ACT_AW'(wr_base_reg + ACT_AW'(j_reg));
    assign sig_acc   = sigmoid_q(acc_reg);
    assign act_we    = (state_reg == S_NFIN) && !is_out;

    // The one shared multiplier: weight times source in the MAC loop, and the two
    // halves of the accumulator times the gain in numeric output mode.
    always_comb
    begin
        mul_a = 33'sd0;
        mul_b = 32'sd0;
        case (state_reg)
            S_MMUL:
            begin
                mul_a = 33'((l_reg == '0) ? $signed(xin_rdata) : $signed(act_rdata));
                mul_b = $signed(w_rdata);
            end
            S_OM1:
            begin
                mul_a = 33'($signed(acc_reg[47:16]));
                mul_b = output_scale_reg;
            end
            S_OM2:
            begin
                mul_a = $signed({17'd0, acc_reg[15:0]});
                mul_b = output_scale_reg;
            end
            default:
            begin
                mul_a = 33'sd0;
                mul_b = 32'sd0;
            end
        endcase
    end

    assign mul_p       = mul_a * mul_b;
    assign mac_sum     = sat48(50'(acc_reg) + 50'(prod_reg >>> 16));
    assign numeric_res = sat32(66'(phi_reg) + 66'(prod_reg >>> 16) + 66'(output_offset_reg));

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_accept)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (item_reg.kind == KIND_WEIGHT)
                begin
                    state_next = S_WWR;
                end
                else if ((item_reg.kind == KIND_FEATURE) && item_reg.last)
                begin
                    state_next = S_NRD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WWR:
            begin
                state_next = S_IDLE;
            end
            S_NRD:
            begin
                state_next = S_NCALC;
            end
            S_NCALC:
            begin
                if (mode_reg[0] && (nspan_s != 32'sd0))
                begin
                    state_next = S_NDIV;
                end
                else if (k_inc == ni_eff)
                begin
                    state_next = S_BRD;
                end
                else
                begin
                    state_next = S_NRD;
                end
            end
            S_NDIV:
            begin
                if (div_cnt_reg == 6'd0)
                begin
                    state_next = S_NDWR;
                end
            end
            S_NDWR:
            begin
                state_next = (k_inc == ni_eff) ? S_BRD : S_NRD;
            end
            S_BRD:
            begin
                state_next = S_BLD;
            end
            S_BLD:
            begin
                state_next = S_MRD;
            end
            S_MRD:
            begin
                state_next = S_MMUL;
            end
            S_MMUL:
            begin
                state_next = S_MACC;
            end
            S_MACC:
            begin
                state_next = (k_inc == prev_n_reg) ? S_NFIN : S_MRD;
            end
            S_NFIN:
            begin
                if (!is_out)
                begin
                    state_next = S_BRD;
                end
                else if (mode_reg[1])
                begin
                    state_next = S_OM1;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_OM1:
            begin
                state_next = S_OM2;
            end
            S_OM2:
            begin
                state_next = S_OSUM;
            end
            S_OSUM:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (res_free)
                begin
                    state_next = node_last ? S_IDLE : S_BRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            num_inputs_reg    <= RST_NUM_INPUTS;
            num_layers_reg    <= RST_NUM_LAYERS;
            layer_sizes_reg   <= RST_LAYER_SIZES;
            num_outputs_reg   <= RST_NUM_OUTPUTS;
            mode_reg          <= RST_MODE;
            output_scale_reg  <= RST_OUTPUT_SCALE;
            output_offset_reg <= RST_OUTPUT_OFFSET;
            k_reg             <= '0;
            j_reg             <= '0;
            prev_n_reg        <= '0;
            l_reg             <= '0;
            wptr_reg          <= '0;
            rd_base_reg       <= '0;
            wr_base_reg       <= '0;
            div_cnt_reg       <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_NUM_INPUTS:    num_inputs_reg    <= cfg_data[6:0];
                    CFG_NUM_LAYERS:    num_layers_reg    <= cfg_data[2:0];
                    CFG_LAYER_SIZES:   layer_sizes_reg   <= cfg_data;
                    CFG_NUM_OUTPUTS:   num_outputs_reg   <= cfg_data[4:0];
                    CFG_MODE:          mode_reg          <= cfg_data[1:0];
                    CFG_OUTPUT_SCALE:  output_scale_reg  <= $signed(cfg_data);
                    CFG_OUTPUT_OFFSET: output_offset_reg <= $signed(cfg_data);
                    default:
                    begin
                    end
                endcase
            end

            // The output register frees as soon as the consumer takes the transfer.
            if ((state_reg == S_EMIT) && res_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_DEC:
                begin
                    k_reg <= '0;
                end
                S_NCALC:
                begin
                    if (mode_reg[0] && (nspan_s != 32'sd0))
                    begin
                        div_cnt_reg <= 6'd47;
                    end
                    else
                    begin
                        k_reg <= k_inc;
                    end
                end
                S_NDIV:
                begin
                    div_cnt_reg <= div_cnt_reg - 6'd1;
                end
                S_NDWR:
                begin
                    k_reg <= k_inc;
                end
                default:
                begin
                end
            endcase

            // Start of the network walk once the last column is prepared.
            if (((state_reg == S_NCALC) && (state_next == S_BRD)) ||
                ((state_reg == S_NDWR) && (state_next == S_BRD)))
            begin
                l_reg       <= '0;
                j_reg       <= '0;
                prev_n_reg  <= ni_eff;
                wptr_reg    <= '0;
                rd_base_reg <= '0;
                wr_base_reg <= '0;
            end

            case (state_reg)
                S_BLD:
                begin
                    k_reg    <= '0;
                    wptr_reg <= (wptr_reg == WT_AW'(MAX_WEIGHTS - 1)) ? '0 : wptr_reg + 1'b1;
                end
                S_MMUL:
                begin
                    wptr_reg <= (wptr_reg == WT_AW'(MAX_WEIGHTS - 1)) ? '0 : wptr_reg + 1'b1;
                end
                S_MACC:
                begin
                    k_reg <= k_inc;
                end
                S_NFIN:
                begin
                    if (!is_out)
                    begin
                        if (node_last)
                        begin
                            l_reg       <= LAY_W'(l_reg + 1'b1);
                            j_reg       <= '0;
                            prev_n_reg  <= CNT_W'(sz_cur);
                            rd_base_reg <= wr_base_reg;
                            wr_base_reg <= ACT_AW'(wr_base_reg + ACT_AW'(MAX_LAYER_NODES));
                        end
                        else
                        begin
                            j_reg <= j_inc;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (res_free)
                    begin
                        j_reg <= j_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            item_reg <= item;
        end
        if (state_reg == S_DEC)
        begin
            wq_reg <= 12'(wq_prod >> 24);
        end

        prod_reg <= mul_p;

        case (state_reg)
            S_NCALC:
            begin
                div_rem_reg <= '0;
                div_q_reg   <= '0;
                div_num_reg <= {d_mag, 16'd0};
                div_den_reg <= nspan_s[31] ? 32'(-nspan_s) : 32'(nspan_s);
                div_neg_reg <= norm_d[31] ^ nspan_s[31];
            end
            S_NDIV:
            begin
                div_rem_reg <= rem_ge ? 32'(rem_sh - {1'b0, div_den_reg}) : rem_sh[31:0];
                div_q_reg   <= {div_q_reg[46:0], rem_ge};
                div_num_reg <= {div_num_reg[46:0], 1'b0};
            end
            S_BLD:
            begin
                acc_reg <= 48'($signed(w_rdata));
            end
            S_MACC:
            begin
                acc_reg <= mac_sum;
            end
            S_NFIN:
            begin
                res_val_reg <= sig_acc;
            end
            S_OM2:
            begin
                phi_reg <= prod_reg;
            end
            S_OSUM:
            begin
                res_val_reg <= numeric_res;
            end
            default:
            begin
            end
        endcase

        if ((state_reg == S_EMIT) && res_free)
        begin
            res_reg.node_index   <= 4'(j_reg);
            res_reg.result_value <= res_val_reg;
            res_reg.final_res    <= node_last;
        end
    end

    // Storage.
    mlp_ram #(.WIDTH(32), .DEPTH(MAX_WEIGHTS), .AW(WT_AW)) u_weight_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (item_reg.value),
        .raddr (wptr_reg),
        .rdata (w_rdata)
    );

    mlp_ram #(.WIDTH(64), .DEPTH(MAX_INPUTS), .AW(IN_AW)) u_norm_ram (
        .clk   (clk),
        .we    (norm_we),
        .waddr (col_addr),
        .wdata ({item_reg.span, item_reg.base}),
        .raddr (k_addr),
        .rdata (norm_rdata)
    );

    mlp_ram #(.WIDTH(32), .DEPTH(MAX_INPUTS), .AW(IN_AW)) u_feature_ram (
        .clk   (clk),
        .we    (feat_we),
        .waddr (col_addr),
        .wdata (item_reg.value),
        .raddr (k_addr),
        .rdata (feat_rdata)
    );

    mlp_ram #(.WIDTH(32), .DEPTH(MAX_INPUTS), .AW(IN_AW)) u_xin_ram (
        .clk   (clk),
        .we    (xin_we),
        .waddr (k_addr),
        .wdata (xin_wdata),
        .raddr (k_addr),
        .rdata (xin_rdata)
    );

    mlp_ram #(.WIDTH(32), .DEPTH(ACT_DEPTH), .AW(ACT_AW)) u_act_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (act_waddr),
        .wdata (sig_acc),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

endmodule
